// ===== src/hxa_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex axial package
// Shared constants and register map for the pixel to hex axial converter.
// ----------------------------------------------------------------------------
package hxa_pkg;

   localparam int POS_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF = 8;
   localparam int SIZE_WIDTH    = 16;
   localparam int OUT_WIDTH     = 16;
   localparam int CSR_AW        = 4;
   localparam int CSR_DW        = 32;

   // round(sqrt(3) * 2^24), 25 bits unsigned
   localparam logic [25:0] SQRT3_Q24 = 26'd29058991;
   localparam int SQRT3_SHIFT = 24;

   localparam logic [1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
   localparam logic [1:0] REG_HEX_SIZE = 2'd2;

   localparam logic [SIZE_WIDTH-1:0] HEX_SIZE_RESET = 16'd256;

endpackage

// ===== src/pixel_to_hex_axial_core.sv =====
// ----------------------------------------------------------------------------
// Pixel to hex axial core
// Converts a Q15.8 world position to pointy-top hex axial coordinates.
// ----------------------------------------------------------------------------
// Accepts one position per clock unless output back pressure stalls the
// pipeline, and returns one result per position, in order. The stages are
// three front stages (origin subtract, sqrt(3) multiply, numerator forming),
// one restoring divider cell per quotient bit (POS_WIDTH + 9 - FRAC_BITS
// cells, all three coordinates side by side) and two rounding stages. Every
// stage has its own valid bit, so bubbles close up under output back
// pressure. Write the origin and hex_size registers only while the pipeline
// is empty; a hex_size of zero acts as one.
module pixel_to_hex_axial_core #(
   parameter int POS_WIDTH = hxa_pkg::POS_WIDTH_DEF,
   parameter int FRAC_BITS = hxa_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, zero pad
   input  logic [((2*POS_WIDTH+7)/8)*8-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // axial_q, axial_r, saturated, zero pad
   output logic [39:0]                         rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hxa_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [hxa_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [hxa_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                csr_pready
);

   localparam int AW  = POS_WIDTH + 26;
   localparam int DW  = FRAC_BITS + 34;
   localparam int QW  = POS_WIDTH + 9 - FRAC_BITS;
   localparam int SW  = hxa_pkg::SIZE_WIDTH;
   localparam int OW  = hxa_pkg::OUT_WIDTH;

   logic signed [POS_WIDTH-1:0] origin_x_ff, origin_y_ff;
   logic [SW-1:0]               hex_size_ff;
   logic                        csr_wr;
   logic [SW-1:0]               size_eff;
   logic [SW+1:0]               size3;
   logic [DW-1:0]               divisor;

   logic                        fr_valid, fr_ready;
   logic [2:0][AW-1:0]          fr_mag;
   logic [2:0]                  fr_neg;

   logic [QW:0]                 c_valid, c_ready;
   logic [2:0][DW-1:0]          c_rem [QW+1];
   logic [2:0][QW-1:0]          c_low [QW+1];
   logic [2:0]                  c_neg [QW+1];

   logic [OW-1:0]               axial_q, axial_r;
   logic                        saturated;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         hex_size_ff <= hxa_pkg::HEX_SIZE_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            hxa_pkg::REG_ORIGIN_X: origin_x_ff <= csr_pwdata[POS_WIDTH-1:0];
            hxa_pkg::REG_ORIGIN_Y: origin_y_ff <= csr_pwdata[POS_WIDTH-1:0];
            hxa_pkg::REG_HEX_SIZE: hex_size_ff <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         hxa_pkg::REG_ORIGIN_X: csr_prdata = hxa_pkg::CSR_DW'(origin_x_ff);
         hxa_pkg::REG_ORIGIN_Y: csr_prdata = hxa_pkg::CSR_DW'(origin_y_ff);
         hxa_pkg::REG_HEX_SIZE: csr_prdata = hxa_pkg::CSR_DW'(hex_size_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // divisor = 3 * size * 2^(FRAC_BITS+16)
   assign size_eff = (hex_size_ff == '0) ? SW'(1) : hex_size_ff;
   assign size3    = {2'b00, size_eff} + {1'b0, size_eff, 1'b0};
   assign divisor  = DW'(size3) << (FRAC_BITS + 16);

   hxa_front #(
      .POS_WIDTH (POS_WIDTH),
      .AW        (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pos_x     (req_tdata[POS_WIDTH-1:0]),
      .pos_y     (req_tdata[2*POS_WIDTH-1:POS_WIDTH]),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_mag   (fr_mag),
      .out_neg   (fr_neg)
   );

   // top numerator bits seed the remainder, the low QW bits shift in
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_rem[0][i] = DW'(fr_mag[i][AW-1:QW]);
         c_low[0][i] = fr_mag[i][QW-1:0];
      end
   end
   assign c_neg[0]   = fr_neg;
   assign c_valid[0] = fr_valid;
   assign fr_ready   = c_ready[0];

   for (genvar g = 0; g < QW; g++) begin : g_cell
      hxa_div_cell #(
         .DW (DW),
         .QW (QW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .divisor   (divisor),
         .in_valid  (c_valid[g]),
         .in_ready  (c_ready[g]),
         .in_rem    (c_rem[g]),
         .in_low    (c_low[g]),
         .in_neg    (c_neg[g]),
         .out_valid (c_valid[g+1]),
         .out_ready (c_ready[g+1]),
         .out_rem   (c_rem[g+1]),
         .out_low   (c_low[g+1]),
         .out_neg   (c_neg[g+1])
      );
   end

   hxa_round #(
      .DW (DW),
      .QW (QW)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .divisor   (divisor),
      .in_valid  (c_valid[QW]),
      .in_ready  (c_ready[QW]),
      .in_rem    (c_rem[QW]),
      .in_quot   (c_low[QW]),
      .in_neg    (c_neg[QW]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .axial_q   (axial_q),
      .axial_r   (axial_r),
      .saturated (saturated)
   );

   assign rsp_tdata = {7'b0, saturated, axial_r, axial_q};

endmodule

// ===== src/hxa_front.sv =====
// ----------------------------------------------------------------------------
// Hex axial front end
// Origin subtract, sqrt(3) multiply and forming of the three numerators as
// sign and magnitude, in three pipeline stages.
// ----------------------------------------------------------------------------
module hxa_front #(
   parameter int POS_WIDTH = hxa_pkg::POS_WIDTH_DEF,
   parameter int AW        = POS_WIDTH + 26
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [POS_WIDTH-1:0]    pos_x,
   input  logic signed [POS_WIDTH-1:0]    pos_y,
   input  logic signed [POS_WIDTH-1:0]    origin_x,
   input  logic signed [POS_WIDTH-1:0]    origin_y,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [2:0][AW-1:0]             out_mag,
   output logic [2:0]                     out_neg
);

   localparam int DXW = POS_WIDTH + 1;
   localparam int NW  = AW + 1;

   logic [2:0]            valid_ff;
   logic [2:0]            valid_in;
   logic [3:0]            rdy;

   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [NW-1:0]  prod_ff, prod_in;
   logic signed [DXW-1:0] dy2_ff;
   logic signed [NW-1:0]  dy_sh, nq, nr, ssum;
   logic [2:0][AW-1:0]    mag_ff, mag_in;
   logic [2:0]            neg_ff, neg_in;

   assign rdy[3] = out_ready;
   assign rdy[2] = !valid_ff[2] || rdy[3];
   assign rdy[1] = !valid_ff[1] || rdy[2];
   assign rdy[0] = !valid_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   assign valid_in[0] = rdy[0] ? in_valid    : valid_ff[0];
   assign valid_in[1] = rdy[1] ? valid_ff[0] : valid_ff[1];
   assign valid_in[2] = rdy[2] ? valid_ff[1] : valid_ff[2];

   assign dx_in = DXW'(pos_x) - DXW'(origin_x);
   assign dy_in = DXW'(pos_y) - DXW'(origin_y);

   assign prod_in = NW'($signed({1'b0, hxa_pkg::SQRT3_Q24})) * NW'(dx_ff);

   always_comb begin
      dy_sh = NW'(dy2_ff) <<< hxa_pkg::SQRT3_SHIFT;
      nq    = prod_ff - dy_sh;
      nr    = dy_sh <<< 1;
      ssum  = prod_ff + dy_sh;
      neg_in[0] = nq[NW-1];
      neg_in[1] = nr[NW-1];
      neg_in[2] = !ssum[NW-1] && (ssum != '0);
      mag_in[0] = AW'(nq[NW-1] ? -nq : nq);
      mag_in[1] = AW'(nr[NW-1] ? -nr : nr);
      mag_in[2] = AW'(ssum[NW-1] ? -ssum : ssum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy[1]) begin
         prod_ff <= prod_in;
         dy2_ff  <= dy_ff;
      end
      if (rdy[2]) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

// ===== src/hxa_div_cell.sv =====
// ----------------------------------------------------------------------------
// Hex axial divider cell
// One restoring division step for the three lanes; yields one quotient bit
// per lane and hands the partial remainder to the next cell.
// ----------------------------------------------------------------------------
module hxa_div_cell #(
   parameter int DW = 42,
   parameter int QW = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [DW-1:0]         divisor,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [2:0][DW-1:0]    in_rem,
   input  logic [2:0][QW-1:0]    in_low,
   input  logic [2:0]            in_neg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [2:0][DW-1:0]    out_rem,
   output logic [2:0][QW-1:0]    out_low,
   output logic [2:0]            out_neg
);

   logic                 valid_ff;
   logic [2:0][DW-1:0]   rem_ff, rem_in;
   logic [2:0][QW-1:0]   low_ff, low_in;
   logic [2:0]           neg_ff;
   logic [2:0][DW:0]     trial;
   logic [2:0]           ge;

   assign in_ready = !valid_ff || out_ready;

   // shift in the next numerator bit, subtract when it fits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i]  = {in_rem[i], in_low[i][QW-1]};
         ge[i]     = trial[i] >= {1'b0, divisor};
         rem_in[i] = ge[i] ? DW'(trial[i] - {1'b0, divisor}) : DW'(trial[i]);
         low_in[i] = {in_low[i][QW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         neg_ff <= in_neg;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_low   = low_ff;
   assign out_neg   = neg_ff;

endmodule

// ===== src/hxa_round.sv =====
// ----------------------------------------------------------------------------
// Hex axial rounding
// Half away from zero rounding with error terms, cube correction of the
// component with the largest error, and 16-bit saturation.
// ----------------------------------------------------------------------------
module hxa_round #(
   parameter int DW = 42,
   parameter int QW = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [DW-1:0]                     divisor,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [2:0][DW-1:0]                in_rem,
   input  logic [2:0][QW-1:0]                in_quot,
   input  logic [2:0]                        in_neg,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [hxa_pkg::OUT_WIDTH-1:0]     axial_q,
   output logic [hxa_pkg::OUT_WIDTH-1:0]     axial_r,
   output logic                              saturated
);

   localparam int KW = QW + 2;
   localparam int CW = (QW + 4 > 17) ? QW + 4 : 17;
   localparam int OW = hxa_pkg::OUT_WIDTH;

   logic [1:0]              valid_ff;
   logic [2:0]              rdy;

   logic [2:0]              up;
   logic [2:0][QW:0]        kmag;
   logic [2:0][KW-1:0]      kv_in, kv_ff;
   logic [2:0][DW-1:0]      err_in, err_ff;

   logic signed [CW-1:0]    qv, rv, sv, qc, rc;
   logic                    q_hi, q_lo, r_hi, r_lo;
   logic [OW-1:0]           q_in, r_in, q_ff, r_ff;
   logic                    sat_in, sat_ff;

   assign rdy[2]   = out_ready;
   assign rdy[1]   = !valid_ff[1] || rdy[2];
   assign rdy[0]   = !valid_ff[0] || rdy[1];
   assign in_ready = rdy[0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up[i]     = {in_rem[i], 1'b0} >= {1'b0, divisor};
         kmag[i]   = {1'b0, in_quot[i]} + (QW+1)'(up[i]);
         kv_in[i]  = in_neg[i] ? -KW'(kmag[i]) : KW'(kmag[i]);
         err_in[i] = up[i] ? divisor - in_rem[i] : in_rem[i];
      end
   end

   always_comb begin
      qv = CW'($signed(kv_ff[0]));
      rv = CW'($signed(kv_ff[1]));
      sv = CW'($signed(kv_ff[2]));
      qc = qv;
      rc = rv;
      if (err_ff[0] > err_ff[1] && err_ff[0] > err_ff[2]) begin
         qc = -rv - sv;
      end else if (err_ff[1] > err_ff[2]) begin
         rc = -qv - sv;
      end
      q_hi   = qc > CW'(32767);
      q_lo   = qc < -CW'(32768);
      r_hi   = rc > CW'(32767);
      r_lo   = rc < -CW'(32768);
      q_in   = q_hi ? OW'(16'h7fff) : (q_lo ? OW'(16'h8000) : OW'(qc));
      r_in   = r_hi ? OW'(16'h7fff) : (r_lo ? OW'(16'h8000) : OW'(rc));
      sat_in = q_hi || q_lo || r_hi || r_lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         if (rdy[1]) valid_ff[1] <= valid_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         kv_ff  <= kv_in;
         err_ff <= err_in;
      end
      if (rdy[1]) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign axial_q   = q_ff;
   assign axial_r   = r_ff;
   assign saturated = sat_ff;

endmodule

// ===== src/hxa_checker.sv =====
// ----------------------------------------------------------------------------
// Hex axial port checker
// Port-level properties of the pixel to hex axial core, bound to the top.
// ----------------------------------------------------------------------------
module hxa_checker #(
   parameter int POS_WIDTH = hxa_pkg::POS_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [((2*POS_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [39:0]                         rsp_tdata,
   input  logic                                csr_pready
);

   // results never appear right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a waiting request transaction holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))
      else $error("stalled request transaction changed");

   // saturation flag implies a clamped coordinate
   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[32]) |->
         (rsp_tdata[15:0] == 16'h7fff || rsp_tdata[15:0] == 16'h8000 ||
          rsp_tdata[31:16] == 16'h7fff || rsp_tdata[31:16] == 16'h8000))
      else $error("saturated set without a clamped coordinate");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result transaction changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready low");

endmodule

bind pixel_to_hex_axial_core hxa_checker #(.POS_WIDTH(POS_WIDTH)) u_hxa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
